// ----- rtl/core/dsed_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dsed_pkg;

  // Frame store depth and the widths that follow from it.
  localparam int MAX_FRAME_BYTES = 16;
  localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);
  localparam int FILL_W          = $clog2(MAX_FRAME_BYTES + 1);

  // Fixed field widths of the two channels.
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 4;
  localparam int LEN_W  = 5;
  localparam int STAT_W = 2;
  localparam int ID_W   = 16;

  // Link control codes.
  localparam logic [BYTE_W-1:0] CODE_STX = 8'h02;
  localparam logic [BYTE_W-1:0] CODE_ETX = 8'h03;
  localparam logic [BYTE_W-1:0] CODE_DLE = 8'h10;

  // Frame status codes.
  localparam logic [STAT_W-1:0] ST_GOOD     = 2'd0;
  localparam logic [STAT_W-1:0] ST_SHORT    = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_RD     = 6'b000100,
    S_EMIT   = 6'b001000,
    S_EMPTY  = 6'b010000,
    S_OVF    = 6'b100000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_byte;
    logic store;
    logic clr_fill;
    logic rd_start;
    logic rd_issue;
    logic rd_next;
    logic emit_byte;
    logic emit_empty;
    logic emit_ovf;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_dle;
    logic is_stx;
    logic is_etx;
    logic fill_zero;
    logic fill_full;
    logic rd_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/dsed_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface dsed_in_if;
  logic                        valid;
  logic                        ready;
  logic [dsed_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dsed_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface dsed_out_if;
  logic                        valid;
  logic                        ready;
  logic [dsed_pkg::BYTE_W-1:0] frame_byte;
  logic [dsed_pkg::IDX_W-1:0]  byte_index;
  logic [dsed_pkg::LEN_W-1:0]  frame_length;
  logic [dsed_pkg::STAT_W-1:0] frame_status;
  logic [dsed_pkg::BYTE_W-1:0] header_bus;
  logic [dsed_pkg::ID_W-1:0]   header_id;
  logic                        last;

  modport source (
    output valid, output frame_byte, output byte_index, output frame_length,
    output frame_status, output header_bus, output header_id, output last,
    input ready
  );
  modport sink (
    input valid, input frame_byte, input byte_index, input frame_length,
    input frame_status, input header_bus, input header_id, input last,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/dle_stx_etx_deframer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// DLE/STX/ETX deframer.
// The in_bus channel carries one raw link byte per beat. Frames open with
// DLE STX and close with DLE ETX; DLE DLE inside a frame is a literal 0x10,
// and any other escaped byte aborts the open frame without a report.
// When a frame closes, the out_bus channel gives one beat per stored byte,
// in order, each with the frame length, the status and the header (bus byte
// and little-endian id), with last set on the final beat. An empty frame
// gives one short beat, and a frame that outgrows the store gives one
// overflow beat.
// Each input beat is accepted and then decoded by the controller, so no new
// beat is taken before the last is decoded. A closing ETX releases each
// byte by a read of the registered store port and an emit, waiting on a
// stalled receiver; in_bus stays not ready until the last beat is loaded.
// Results leave through an output register, so a stalled receiver holds
// the current beat and the release simply waits.
// Reset clears the escape, the open-frame flag, the fill count and the
// output valid; the store itself is not cleared and needs no clearing pass.
module dle_stx_etx_deframer (
  input  logic        clk,
  input  logic        rst_n,
  dsed_in_if.sink     in_bus,
  dsed_out_if.source  out_bus
);

  dsed_pkg::cmd_t  cmd;
  dsed_pkg::stat_t stat;
  logic            in_ready;

  // Controller: escape and frame tracking, release sequencing.
  dsed_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_bus.ready = in_ready;

  // Datapath: byte register, frame store, header capture and output register.
  dsed_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .rx_byte      (in_bus.rx_byte),
    .out_ready    (out_bus.ready),
    .out_valid    (out_bus.valid),
    .frame_byte   (out_bus.frame_byte),
    .byte_index   (out_bus.byte_index),
    .frame_length (out_bus.frame_length),
    .frame_status (out_bus.frame_status),
    .header_bus   (out_bus.header_bus),
    .header_id    (out_bus.header_id),
    .last         (out_bus.last)
  );

endmodule

`default_nettype wire

// ----- rtl/core/dsed_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dsed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/core/dsed_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dsed_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dsed_pkg::cmd_t              cmd,
  output dsed_pkg::stat_t             stat,
  input  logic [dsed_pkg::BYTE_W-1:0] rx_byte,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [dsed_pkg::BYTE_W-1:0] frame_byte,
  output logic [dsed_pkg::IDX_W-1:0]  byte_index,
  output logic [dsed_pkg::LEN_W-1:0]  frame_length,
  output logic [dsed_pkg::STAT_W-1:0] frame_status,
  output logic [dsed_pkg::BYTE_W-1:0] header_bus,
  output logic [dsed_pkg::ID_W-1:0]   header_id,
  output logic                        last
);

  logic [dsed_pkg::BYTE_W-1:0] byte_r;
  logic [dsed_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [dsed_pkg::ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [dsed_pkg::BYTE_W-1:0] hdr_bus_r;
  logic [dsed_pkg::ID_W-1:0]   hdr_id_r;
  logic [dsed_pkg::BYTE_W-1:0] ram_rdata;
  logic                        good;

  logic                        out_valid_r;
  logic [dsed_pkg::BYTE_W-1:0] frame_byte_r;
  logic [dsed_pkg::IDX_W-1:0]  byte_index_r;
  logic [dsed_pkg::LEN_W-1:0]  frame_length_r;
  logic [dsed_pkg::STAT_W-1:0] frame_status_r;
  logic [dsed_pkg::BYTE_W-1:0] header_bus_r;
  logic [dsed_pkg::ID_W-1:0]   header_id_r;
  logic                        last_r;

  dsed_ram #(
    .WIDTH (dsed_pkg::BYTE_W),
    .DEPTH (dsed_pkg::MAX_FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (fill_r[dsed_pkg::ADDR_W-1:0]),
    .wdata (byte_r),
    .re    (cmd.rd_issue),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.clr_fill) begin
      fill_nxt = '0;
    end else if (cmd.store) begin
      fill_nxt = fill_r + dsed_pkg::FILL_W'(1);
    end
    rd_idx_nxt = rd_idx_r;
    if (cmd.rd_start) begin
      rd_idx_nxt = '0;
    end else if (cmd.rd_next) begin
      rd_idx_nxt = rd_idx_r + dsed_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      rd_idx_r <= '0;
    end else begin
      fill_r   <= fill_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  // The first three bytes are caught on their way into the store, so the
  // header is ready when the frame closes.
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      byte_r <= rx_byte;
    end
    if (cmd.store) begin
      if (fill_r == dsed_pkg::FILL_W'(0)) begin
        hdr_bus_r <= byte_r;
      end
      if (fill_r == dsed_pkg::FILL_W'(1)) begin
        hdr_id_r[7:0] <= byte_r;
      end
      if (fill_r == dsed_pkg::FILL_W'(2)) begin
        hdr_id_r[15:8] <= byte_r;
      end
    end
  end

  assign good = (fill_r >= dsed_pkg::FILL_W'(3));

  always_comb begin
    stat.is_dle    = (byte_r == dsed_pkg::CODE_DLE);
    stat.is_stx    = (byte_r == dsed_pkg::CODE_STX);
    stat.is_etx    = (byte_r == dsed_pkg::CODE_ETX);
    stat.fill_zero = (fill_r == '0);
    stat.fill_full = (fill_r == dsed_pkg::FILL_W'(dsed_pkg::MAX_FRAME_BYTES));
    stat.rd_last   = ((dsed_pkg::FILL_W'(rd_idx_r) + dsed_pkg::FILL_W'(1)) == fill_r);
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_byte || cmd.emit_empty || cmd.emit_ovf) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      frame_byte_r   <= ram_rdata;
      byte_index_r   <= dsed_pkg::IDX_W'(rd_idx_r);
      frame_length_r <= dsed_pkg::LEN_W'(fill_r);
      frame_status_r <= good ? dsed_pkg::ST_GOOD : dsed_pkg::ST_SHORT;
      header_bus_r   <= good ? hdr_bus_r : '0;
      header_id_r    <= good ? hdr_id_r : '0;
      last_r         <= stat.rd_last;
    end else if (cmd.emit_empty || cmd.emit_ovf) begin
      frame_byte_r   <= '0;
      byte_index_r   <= '0;
      frame_length_r <= cmd.emit_ovf ? dsed_pkg::LEN_W'(dsed_pkg::MAX_FRAME_BYTES) : '0;
      frame_status_r <= cmd.emit_ovf ? dsed_pkg::ST_OVERFLOW : dsed_pkg::ST_SHORT;
      header_bus_r   <= '0;
      header_id_r    <= '0;
      last_r         <= 1'b1;
    end
  end

  assign out_valid    = out_valid_r;
  assign frame_byte   = frame_byte_r;
  assign byte_index   = byte_index_r;
  assign frame_length = frame_length_r;
  assign frame_status = frame_status_r;
  assign header_bus   = header_bus_r;
  assign header_id    = header_id_r;
  assign last         = last_r;

endmodule

`default_nettype wire

// ----- rtl/core/dsed_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dsed_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  dsed_pkg::stat_t stat,
  output dsed_pkg::cmd_t  cmd
);

  dsed_pkg::state_t state_r, state_nxt;
  logic             esc_r, esc_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic             is_data;

  assign in_ready = (state_r == dsed_pkg::S_IDLE);

  // A byte is payload unless it arms an escape or is an escaped byte other than DLE.
  assign is_data = esc_r ? stat.is_dle : !stat.is_dle;

  always_comb begin
    state_nxt    = state_r;
    esc_nxt      = esc_r;
    in_frame_nxt = in_frame_r;
    cmd          = '0;
    cmd.load_byte = in_valid && in_ready;

    unique case (state_r)
      dsed_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = dsed_pkg::S_DECODE;
        end
      end
      dsed_pkg::S_DECODE: begin
        state_nxt = dsed_pkg::S_IDLE;
        esc_nxt   = !esc_r && stat.is_dle;
        if (esc_r && stat.is_stx) begin
          in_frame_nxt = 1'b1;
          cmd.clr_fill = 1'b1;
        end else if (esc_r && stat.is_etx) begin
          if (in_frame_r) begin
            in_frame_nxt = 1'b0;
            cmd.rd_start = 1'b1;
            state_nxt    = stat.fill_zero ? dsed_pkg::S_EMPTY : dsed_pkg::S_RD;
          end
        end else if (!is_data) begin
          if (esc_r) begin
            in_frame_nxt = 1'b0;
          end
        end else if (in_frame_r) begin
          if (!stat.fill_full) begin
            cmd.store = 1'b1;
          end else begin
            in_frame_nxt = 1'b0;
            state_nxt    = dsed_pkg::S_OVF;
          end
        end
      end
      dsed_pkg::S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = dsed_pkg::S_EMIT;
      end
      dsed_pkg::S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_byte = 1'b1;
          if (stat.rd_last) begin
            state_nxt = dsed_pkg::S_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
            state_nxt   = dsed_pkg::S_RD;
          end
        end
      end
      dsed_pkg::S_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = dsed_pkg::S_IDLE;
        end
      end
      dsed_pkg::S_OVF: begin
        if (stat.out_free) begin
          cmd.emit_ovf = 1'b1;
          state_nxt    = dsed_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dsed_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= dsed_pkg::S_IDLE;
      esc_r      <= 1'b0;
      in_frame_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      esc_r      <= esc_nxt;
      in_frame_r <= in_frame_nxt;
    end
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == dsed_pkg::S_DECODE)
    else $error("accepted beat not followed by decode");

  a_store_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> in_frame_r && !stat.fill_full)
    else $error("store written outside a frame or when full");

  a_frame_opens_escaped: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_frame_r) |-> $past(esc_r))
    else $error("frame opened without an escape");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dsed_pkg::S_EMIT && stat.out_free && stat.rd_last
    |=> state_r == dsed_pkg::S_IDLE)
    else $error("release did not end after the last byte");

endmodule

`default_nettype wire
